FILE: rtl/dlpg_pkg.sv
// Shared constants and types for the DDA line point generator.
// No dependencies; every other file refers to it by scoped names.
package dlpg_pkg;

  localparam int unsigned COORD_BITS_DEF  = 11;
  localparam int unsigned FRAC_BITS_DEF   = 16;
  localparam int unsigned CMD_QUEUE_DEPTH = 2;

  // Request codes on the input channel.
  localparam logic REQ_LOAD    = 1'b0;
  localparam logic REQ_ADVANCE = 1'b1;

  // Classified command passed from the front end to the back end.
  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_LOAD    = 2'd1,
    CMD_ADVANCE = 2'd2
  } cmd_kind_e;

endpackage

FILE: rtl/dlpg_front.sv
// Front end: accepts requests, measures the line and classifies each request.
// Depends on dlpg_pkg.
module dlpg_front #(
  parameter int unsigned COORD_BITS = dlpg_pkg::COORD_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  req_type_i,
  input  logic [COORD_BITS-1:0] x_start_i,
  input  logic [COORD_BITS-1:0] y_start_i,
  input  logic [COORD_BITS-1:0] x_end_i,
  input  logic [COORD_BITS-1:0] y_end_i,
  output logic                  cmd_valid_o,
  input  logic                  cmd_ready_i,
  output dlpg_pkg::cmd_kind_e   cmd_kind_o,
  output logic [COORD_BITS-1:0] cmd_xs_o,
  output logic [COORD_BITS-1:0] cmd_ys_o,
  output logic [COORD_BITS-1:0] cmd_adx_o,
  output logic [COORD_BITS-1:0] cmd_ady_o,
  output logic [COORD_BITS-1:0] cmd_len_o,
  output logic                  cmd_neg_x_o,
  output logic                  cmd_neg_y_o
);

  logic                  valid_q, valid_d;
  dlpg_pkg::cmd_kind_e   kind_q, kind_d;
  logic [COORD_BITS-1:0] xs_q, ys_q, adx_q, ady_q, len_q;
  logic [COORD_BITS-1:0] adx_d, ady_d, len_d;
  logic                  neg_x_q, neg_y_q, neg_x_d, neg_y_d;
  logic                  accept;

  assign in_ready_o = !valid_q || cmd_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    neg_x_d = x_end_i < x_start_i;
    neg_y_d = y_end_i < y_start_i;
    adx_d   = neg_x_d ? (x_start_i - x_end_i) : (x_end_i - x_start_i);
    ady_d   = neg_y_d ? (y_start_i - y_end_i) : (y_end_i - y_start_i);
    len_d   = (adx_d > ady_d) ? adx_d : ady_d;
    if (req_type_i == dlpg_pkg::REQ_ADVANCE) begin
      kind_d = dlpg_pkg::CMD_ADVANCE;
    end else if (len_d == '0) begin
      kind_d = dlpg_pkg::CMD_CLEAR;
    end else begin
      kind_d = dlpg_pkg::CMD_LOAD;
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (cmd_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q  <= kind_d;
      xs_q    <= x_start_i;
      ys_q    <= y_start_i;
      adx_q   <= adx_d;
      ady_q   <= ady_d;
      len_q   <= len_d;
      neg_x_q <= neg_x_d;
      neg_y_q <= neg_y_d;
    end
  end

  assign cmd_valid_o = valid_q;
  assign cmd_kind_o  = kind_q;
  assign cmd_xs_o    = xs_q;
  assign cmd_ys_o    = ys_q;
  assign cmd_adx_o   = adx_q;
  assign cmd_ady_o   = ady_q;
  assign cmd_len_o   = len_q;
  assign cmd_neg_x_o = neg_x_q;
  assign cmd_neg_y_o = neg_y_q;

endmodule

FILE: rtl/dlpg_queue.sv
// Small command queue between front and back end.
// Depends on dlpg_pkg for the default depth.
module dlpg_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = dlpg_pkg::CMD_QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign push_ready_o = count_q != CNT_W'(DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;
  assign pop_data_o   = mem_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (do_push) begin
      wptr_d = (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

FILE: rtl/dlpg_back.sv
// Back end: line setup with a bit-serial divider, point stepping, output register.
// Depends on dlpg_pkg.
module dlpg_back #(
  parameter int unsigned COORD_BITS = dlpg_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = dlpg_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cmd_valid_i,
  output logic                           cmd_pop_o,
  input  dlpg_pkg::cmd_kind_e            cmd_kind_i,
  input  logic [COORD_BITS-1:0]          cmd_xs_i,
  input  logic [COORD_BITS-1:0]          cmd_ys_i,
  input  logic [COORD_BITS-1:0]          cmd_adx_i,
  input  logic [COORD_BITS-1:0]          cmd_ady_i,
  input  logic [COORD_BITS-1:0]          cmd_len_i,
  input  logic                           cmd_neg_x_i,
  input  logic                           cmd_neg_y_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [COORD_BITS+FRAC_BITS-1:0] point_x_o,
  output logic [COORD_BITS+FRAC_BITS-1:0] point_y_o,
  output logic                           last_point_o
);

  localparam int unsigned ACC_W = COORD_BITS + FRAC_BITS;
  localparam int unsigned INC_W = FRAC_BITS + 2;
  localparam int unsigned Q_W   = FRAC_BITS + 1;
  localparam int unsigned CNT_W = $clog2(FRAC_BITS);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DIV  = 2'b10
  } state_e;

  state_e                state_q, state_d;
  logic [ACC_W-1:0]      acc_x_q, acc_x_d, acc_y_q, acc_y_d;
  logic [INC_W-1:0]      step_x_q, step_x_d, step_y_q, step_y_d;
  logic [COORD_BITS-1:0] left_q, left_d;
  logic [COORD_BITS-1:0] len_q, len_d;
  logic [COORD_BITS-1:0] rem_x_q, rem_x_d, rem_y_q, rem_y_d;
  logic [Q_W-1:0]        quo_x_q, quo_x_d, quo_y_q, quo_y_d;
  logic                  neg_x_q, neg_x_d, neg_y_q, neg_y_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  out_valid_q, out_valid_d;
  logic [ACC_W-1:0]      pt_x_q, pt_y_q;
  logic                  last_q;
  logic                  out_free, out_load, pop;
  logic                  top_x, top_y, ge_x, ge_y;
  logic [COORD_BITS:0]   dbl_x, dbl_y;
  logic [Q_W-1:0]        quo_x_fin, quo_y_fin;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    pop      = 1'b0;
    out_load = 1'b0;
    if (state_q == ST_IDLE && cmd_valid_i) begin
      case (cmd_kind_i)
        dlpg_pkg::CMD_ADVANCE: begin
          // drop advances with nothing armed; otherwise wait for a free slot
          pop      = (left_q == '0) || out_free;
          out_load = (left_q != '0) && out_free;
        end
        default: pop = 1'b1;
      endcase
    end
  end

  assign cmd_pop_o = pop;

  // restoring division of (mag << FRAC_BITS) by len, one quotient bit per cycle
  assign top_x = cmd_adx_i >= cmd_len_i;
  assign top_y = cmd_ady_i >= cmd_len_i;
  assign dbl_x = {rem_x_q, 1'b0};
  assign dbl_y = {rem_y_q, 1'b0};
  assign ge_x  = dbl_x >= {1'b0, len_q};
  assign ge_y  = dbl_y >= {1'b0, len_q};
  assign quo_x_fin = {quo_x_q[Q_W-2:0], ge_x};
  assign quo_y_fin = {quo_y_q[Q_W-2:0], ge_y};

  always_comb begin
    state_d     = state_q;
    acc_x_d     = acc_x_q;
    acc_y_d     = acc_y_q;
    step_x_d    = step_x_q;
    step_y_d    = step_y_q;
    left_d      = left_q;
    len_d       = len_q;
    rem_x_d     = rem_x_q;
    rem_y_d     = rem_y_q;
    quo_x_d     = quo_x_q;
    quo_y_d     = quo_y_q;
    neg_x_d     = neg_x_q;
    neg_y_d     = neg_y_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
    case (state_q)
      ST_IDLE: begin
        if (pop) begin
          case (cmd_kind_i)
            dlpg_pkg::CMD_CLEAR: begin
              left_d = '0;
            end
            dlpg_pkg::CMD_LOAD: begin
              acc_x_d = {cmd_xs_i, {FRAC_BITS{1'b0}}};
              acc_y_d = {cmd_ys_i, {FRAC_BITS{1'b0}}};
              left_d  = '0;
              len_d   = cmd_len_i;
              neg_x_d = cmd_neg_x_i;
              neg_y_d = cmd_neg_y_i;
              rem_x_d = top_x ? (cmd_adx_i - cmd_len_i) : cmd_adx_i;
              rem_y_d = top_y ? (cmd_ady_i - cmd_len_i) : cmd_ady_i;
              quo_x_d = {{(Q_W-1){1'b0}}, top_x};
              quo_y_d = {{(Q_W-1){1'b0}}, top_y};
              cnt_d   = '0;
              state_d = ST_DIV;
            end
            dlpg_pkg::CMD_ADVANCE: begin
              if (out_load) begin
                acc_x_d = acc_x_q + {{(ACC_W-INC_W){step_x_q[INC_W-1]}}, step_x_q};
                acc_y_d = acc_y_q + {{(ACC_W-INC_W){step_y_q[INC_W-1]}}, step_y_q};
                left_d  = left_q - 1'b1;
              end
            end
            default: begin
              left_d = left_q;
            end
          endcase
        end
      end
      ST_DIV: begin
        rem_x_d = ge_x ? COORD_BITS'(dbl_x - {1'b0, len_q}) : COORD_BITS'(dbl_x);
        rem_y_d = ge_y ? COORD_BITS'(dbl_y - {1'b0, len_q}) : COORD_BITS'(dbl_y);
        quo_x_d = quo_x_fin;
        quo_y_d = quo_y_fin;
        cnt_d   = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(FRAC_BITS - 1)) begin
          // apply sign and arm the run
          step_x_d = neg_x_q ? (INC_W'(0) - {1'b0, quo_x_fin}) : {1'b0, quo_x_fin};
          step_y_d = neg_y_q ? (INC_W'(0) - {1'b0, quo_y_fin}) : {1'b0, quo_y_fin};
          left_d   = len_q;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      acc_x_q     <= '0;
      acc_y_q     <= '0;
      step_x_q    <= '0;
      step_y_q    <= '0;
      left_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      acc_x_q     <= acc_x_d;
      acc_y_q     <= acc_y_d;
      step_x_q    <= step_x_d;
      step_y_q    <= step_y_d;
      left_q      <= left_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q   <= len_d;
    rem_x_q <= rem_x_d;
    rem_y_q <= rem_y_d;
    quo_x_q <= quo_x_d;
    quo_y_q <= quo_y_d;
    neg_x_q <= neg_x_d;
    neg_y_q <= neg_y_d;
    if (out_load) begin
      pt_x_q <= acc_x_q;
      pt_y_q <= acc_y_q;
      last_q <= left_q == COORD_BITS'(1);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign point_x_o    = pt_x_q;
  assign point_y_o    = pt_y_q;
  assign last_point_o = last_q;

  a_no_pop_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> !pop)
    else $error("command popped during line setup");

  a_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten");

  a_left_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> left_q == $past(left_q) - 1'b1)
    else $error("points_left did not step down on an emitted point");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && left_q == COORD_BITS'(1) |=> last_q && out_valid_q && left_q == '0)
    else $error("final point not flagged");

endmodule

FILE: rtl/dda_line_point_generator_top.sv
// DDA line point generator. An advance goes from the front register through the queue into
// the output register when the path is clear. Throughput: one advance per cycle sustained
// while the output is taken; a line load keeps the back end busy for the bit-serial divider;
// a load with equal endpoints becomes a clear that skips it. The front register and queue
// (2 entries) keep taking requests while the back end works. Reset (rst_ni, async, low)
// empties the queue and output register and disarms the line; no clearing pass is needed.
module dda_line_point_generator_top #(
  parameter int unsigned COORD_BITS = dlpg_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = dlpg_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            req_type_i,
  input  logic [COORD_BITS-1:0]           x_start_i,
  input  logic [COORD_BITS-1:0]           y_start_i,
  input  logic [COORD_BITS-1:0]           x_end_i,
  input  logic [COORD_BITS-1:0]           y_end_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [COORD_BITS+FRAC_BITS-1:0] point_x_o,
  output logic [COORD_BITS+FRAC_BITS-1:0] point_y_o,
  output logic                            last_point_o
);

  localparam int unsigned CMD_W = 2 + 5 * COORD_BITS + 2;

  logic                  f_valid, f_ready;
  dlpg_pkg::cmd_kind_e   f_kind, b_kind;
  logic [COORD_BITS-1:0] f_xs, f_ys, f_adx, f_ady, f_len;
  logic [COORD_BITS-1:0] b_xs, b_ys, b_adx, b_ady, b_len;
  logic                  f_neg_x, f_neg_y, b_neg_x, b_neg_y;
  logic [CMD_W-1:0]      push_data, pop_data;
  logic [1:0]            b_kind_bits;
  logic                  q_valid, q_pop;

  dlpg_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .req_type_i (req_type_i),
    .x_start_i  (x_start_i),
    .y_start_i  (y_start_i),
    .x_end_i    (x_end_i),
    .y_end_i    (y_end_i),
    .cmd_valid_o(f_valid),
    .cmd_ready_i(f_ready),
    .cmd_kind_o (f_kind),
    .cmd_xs_o   (f_xs),
    .cmd_ys_o   (f_ys),
    .cmd_adx_o  (f_adx),
    .cmd_ady_o  (f_ady),
    .cmd_len_o  (f_len),
    .cmd_neg_x_o(f_neg_x),
    .cmd_neg_y_o(f_neg_y)
  );

  assign push_data = {f_kind, f_xs, f_ys, f_adx, f_ady, f_len, f_neg_x, f_neg_y};

  dlpg_queue #(
    .WIDTH(CMD_W),
    .DEPTH(dlpg_pkg::CMD_QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(f_valid),
    .push_ready_o(f_ready),
    .push_data_i (push_data),
    .pop_valid_o (q_valid),
    .pop_i       (q_pop),
    .pop_data_o  (pop_data)
  );

  assign {b_kind_bits, b_xs, b_ys, b_adx, b_ady, b_len, b_neg_x, b_neg_y} = pop_data;
  assign b_kind = dlpg_pkg::cmd_kind_e'(b_kind_bits);

  dlpg_back #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_pop_o   (q_pop),
    .cmd_kind_i  (b_kind),
    .cmd_xs_i    (b_xs),
    .cmd_ys_i    (b_ys),
    .cmd_adx_i   (b_adx),
    .cmd_ady_i   (b_ady),
    .cmd_len_i   (b_len),
    .cmd_neg_x_i (b_neg_x),
    .cmd_neg_y_i (b_neg_y),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .point_x_o   (point_x_o),
    .point_y_o   (point_y_o),
    .last_point_o(last_point_o)
  );

endmodule
